// ===== hdl/modinv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modinv_pkg
// Types and constants shared by the modular inverse core: beat structs and
// sequencer states.
// ----------------------------------------------------------------------------
package modinv_pkg;

    localparam int FIELD_W = 63;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] modulus;
    } in_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        logic [FIELD_W-1:0] divisor;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_UPDATE,
        ST_ADJUST,
        ST_REDUCE
    } state_t;

endpackage

// ===== hdl/modular_inverse_ext_euclid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_core
// Modular inverse and gcd by the extended Euclidean algorithm on one shared
// restoring divider.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Operands use their low
// WORD_BITS-1 bits. Every Euclid step runs the quotient through a one bit per
// cycle restoring divider, folding each quotient bit into the coefficient
// update as it appears; a step runs a set-up state, the divide loop and an
// update state. A zero modulus answers on the next cycle. The result is
// shown for exactly one cycle with done high and the receiver cannot stall
// it. inverse is the value's Bezout coefficient reduced modulo the modulus;
// it is the true inverse only when divisor is 1.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_core
    import modinv_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_beat_t  operands,
    output logic      done,
    output out_beat_t result
);

    localparam int N     = WORD_BITS - 1;
    localparam int W     = WORD_BITS;
    localparam int CNT_W = $clog2(N);

    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    logic [N-1:0]         r_prev_reg, r_prev_next;
    logic [N-1:0]         r_cur_reg, r_cur_next;
    logic signed [W-1:0]  s_prev_reg, s_prev_next;
    logic signed [W-1:0]  s_cur_reg, s_cur_next;
    logic [N-1:0]         mod_reg, mod_next;
    logic [N-1:0]         rem_reg, rem_next;
    logic [N-1:0]         dvd_reg, dvd_next;
    logic signed [W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [N-1:0]         inv_reg, inv_next;
    out_beat_t            res_reg, res_next;

    logic [N:0]           rem_sh;
    logic [N+1:0]         diff;
    logic                 q_bit;
    logic signed [W-1:0]  acc_sum;
    logic signed [W-1:0]  s_step;
    logic signed [W-1:0]  fix_sum;
    logic [N:0]           red_diff;
    logic [N-1:0]         in_value;
    logic [N-1:0]         in_modulus;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    assign in_value   = operands.value[N-1:0];
    assign in_modulus = operands.modulus[N-1:0];

    // shared datapath
    assign rem_sh   = {rem_reg, dvd_reg[N-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, r_cur_reg};
    assign q_bit    = !diff[N+1];
    assign acc_sum  = (acc_reg <<< 1) + (q_bit ? s_cur_reg : '0);
    assign s_step   = s_prev_reg - acc_reg;
    assign fix_sum  = s_prev_reg + $signed({1'b0, mod_reg});
    assign red_diff = {1'b0, inv_reg} - {1'b0, mod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_prev_reg <= r_prev_next;
        r_cur_reg  <= r_cur_next;
        s_prev_reg <= s_prev_next;
        s_cur_reg  <= s_cur_next;
        mod_reg    <= mod_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        inv_reg    <= inv_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        r_prev_next = r_prev_reg;
        r_cur_next  = r_cur_reg;
        s_prev_next = s_prev_reg;
        s_cur_next  = s_cur_reg;
        mod_next    = mod_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        inv_next    = inv_reg;
        res_next    = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (in_modulus == '0)
                    begin
                        // no reduction possible, gcd is the value
                        res_next.inverse = '0;
                        res_next.divisor = FIELD_W'(in_value);
                        done_next        = 1'b1;
                    end
                    else
                    begin
                        r_prev_next = in_modulus;
                        r_cur_next  = in_value;
                        s_prev_next = '0;
                        s_cur_next  = W'(1);
                        mod_next    = in_modulus;
                        state_next  = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (r_cur_reg == '0)
                begin
                    state_next = ST_ADJUST;
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = r_prev_reg;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // quotient bit also scales s_cur into the accumulator
                rem_next = q_bit ? diff[N-1:0] : rem_sh[N-1:0];
                dvd_next = dvd_reg << 1;
                acc_next = acc_sum;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                r_prev_next = r_cur_reg;
                r_cur_next  = rem_reg;
                s_prev_next = s_cur_reg;
                s_cur_next  = s_step;
                state_next  = ST_EVAL;
            end
            ST_ADJUST:
            begin
                inv_next   = s_prev_reg[W-1] ? fix_sum[N-1:0] : s_prev_reg[N-1:0];
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                res_next.inverse = FIELD_W'(red_diff[N] ? inv_reg : red_diff[N-1:0]);
                res_next.divisor = FIELD_W'(r_prev_reg);
                done_next        = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither started nor answered");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (r_cur_reg != '0))
        else $error("division by zero remainder");

    a_reduce_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE) |=> (done && !busy))
        else $error("final reduction did not deliver a result");
`endif

endmodule
